[hdl/tx2rgba_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and functions for the texel to RGBA8888 converter.
// No dependencies; used by the core and by its checker.

package tx2rgba_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [2:0] {
      FMT_RGBA8    = 3'd0,
      FMT_RGB8     = 3'd1,
      FMT_BGRA8    = 3'd2,
      FMT_RGB565   = 3'd3,
      FMT_RGBA4444 = 3'd4,
      FMT_RGBA5551 = 3'd5
   } pixel_format_type;

   // Effect of one set bit of (crc ^ data) after all 32 bit steps of the
   // reflected CRC. Evaluated on constant arguments only.
   function automatic logic [31:0] crc_column(input int unsigned idx);
      logic [31:0] c;
      c = 32'd1 << idx;
      for (int k = 0; k < 32; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // CRC-32 over four bytes, least significant byte first. The 32 shift
   // steps are linear, so this is one XOR tree over the input bits.
   function automatic logic [31:0] crc32_word(input logic [31:0] crc,
                                              input logic [31:0] data);
      logic [31:0] x;
      logic [31:0] r;
      x = crc ^ data;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            r = r ^ crc_column(i);
         end
      end
      return r;
   endfunction

   // v*255/31 truncated equals 8v + floor(7v/31); the second term counts
   // the thresholds ceil(31k/7) that v reaches.
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [2:0] c;
      c = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
        + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
      return {v, 3'b000} + {5'b00000, c};
   endfunction

   // v*255/63 truncated equals 4v + floor(v/21).
   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [1:0] c;
      c = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
      return {v, 2'b00} + {6'b000000, c};
   endfunction

   // v*17 is the nibble repeated.
   function automatic logic [7:0] widen4(input logic [3:0] v);
      return {v, v};
   endfunction

endpackage

[hdl/texel_to_rgba8_with_crc32_core.sv]
`timescale 1ns / 1ps
// Texel to RGBA8888 converter with a running CRC-32 over the output bytes.
// Depends on tx2rgba_pkg for the format codes, channel widening and CRC.

// This core takes one source texel per item, in the pixel format held in
// its configuration register, and returns one RGBA8888 word per item along
// with the inverted running CRC-32 of every output byte of the image so
// far (bytes R, G, B, A in that order) and a flag that marks the closing
// texel. Throughput is one item per clock cycle while rsp_ready holds; a
// texel is captured by the input register and then by the result register
// that frame the conversion and CRC logic, and the move into the result
// register waits while the result channel is stalled. The CRC register
// returns to all ones after a texel marked last, so the next item starts a
// fresh image. Write the format only while no item is in flight; codes 6
// and 7 pass the texel through unchanged.

module texel_to_rgba8_with_crc32_core
   import tx2rgba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_pixel_format,
   // Texel input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_texel_word,
   input  logic        req_last_texel,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_rgba_word,
   output logic [31:0] rsp_image_crc,
   output logic        rsp_crc_final
);

   pixel_format_type pixel_format_ff;

   // Input register stage.
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [31:0] in_texel_ff;
   logic        in_last_ff;

   // Result register stage.
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] out_rgba_ff;
   logic [31:0] out_crc_ff;
   logic        out_final_ff;

   // Running CRC, not inverted.
   logic [31:0] crc_state_ff;
   logic [31:0] crc_state_in;

   logic        advance;
   logic [31:0] rgba;
   logic [31:0] crc_next;
   logic [15:0] p16;

   // The configuration register is always ready to take a write.
   assign csr_ready = 1'b1;

   // An item moves from the input register into the result register when
   // the result register is empty or is being drained in the same cycle.
   // The input register then frees up, so a new item can enter every cycle while items keep advancing.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Format conversion, purely combinational from the input register.
   assign p16 = in_texel_ff[15:0];

   always_comb begin
      case (pixel_format_ff)
         FMT_RGB8: begin
            rgba = {ALPHA_OPAQUE, in_texel_ff[23:0]};
         end
         FMT_BGRA8: begin
            rgba = {in_texel_ff[31:24], in_texel_ff[7:0],
                    in_texel_ff[15:8], in_texel_ff[23:16]};
         end
         FMT_RGB565: begin
            rgba = {ALPHA_OPAQUE, widen5(p16[4:0]), widen6(p16[10:5]),
                    widen5(p16[15:11])};
         end
         FMT_RGBA4444: begin
            rgba = {widen4(p16[3:0]), widen4(p16[7:4]), widen4(p16[11:8]),
                    widen4(p16[15:12])};
         end
         FMT_RGBA5551: begin
            rgba = {(p16[0] ? ALPHA_OPAQUE : 8'h00), widen5(p16[5:1]),
                    widen5(p16[10:6]), widen5(p16[15:11])};
         end
         default: begin
            // RGBA8 and the undefined codes pass the texel through.
            rgba = in_texel_ff;
         end
      endcase
   end

   // The four output bytes fold into the CRC as one 32-bit XOR network.
   assign crc_next     = crc32_word(crc_state_ff, rgba);
   assign crc_state_in = in_last_ff ? CRC_INIT : crc_next;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_RGBA8;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         crc_state_ff    <= CRC_INIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            pixel_format_ff <= pixel_format_type'(csr_pixel_format);
         end
         if (advance) begin
            crc_state_ff <= crc_state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_texel_ff <= req_texel_word;
         in_last_ff  <= req_last_texel;
      end
      if (advance) begin
         out_rgba_ff  <= rgba;
         out_crc_ff   <= ~crc_next;
         out_final_ff <= in_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_rgba_word = out_rgba_ff;
   assign rsp_image_crc = out_crc_ff;
   assign rsp_crc_final = out_final_ff;

endmodule

[hdl/tx2rgba_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the texel to RGBA8888 converter core.
// Depends on tx2rgba_pkg; bound to texel_to_rgba8_with_crc32_core below.

module tx2rgba_checker
   import tx2rgba_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_pixel_format,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_rgba_word,
   input logic [31:0] rsp_image_crc,
   input logic        rsp_crc_final
);

   logic [2:0] format_ff;

   // Shadow copy of the format register as seen on the write channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_RGBA8;
      end else if (csr_valid && csr_ready) begin
         format_ff <= csr_pixel_format;
      end
   end

   // A stalled result keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rgba_word)
         && $stable(rsp_image_crc) && $stable(rsp_crc_final))
      else $error("stalled result changed");

   // With the result side empty the core always takes a texel.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while result register empty");

   // An accepted texel moves on from the input register to the result register when the output is free.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("accepted texel did not reach the result register");

   // Formats without an alpha channel always produce opaque alpha.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (format_ff == FMT_RGB8 || format_ff == FMT_RGB565)
         |-> rsp_rgba_word[31:24] == ALPHA_OPAQUE)
      else $error("opaque format produced non-opaque alpha");

endmodule

bind texel_to_rgba8_with_crc32_core tx2rgba_checker u_tx2rgba_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready),
   .csr_pixel_format (csr_pixel_format),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_rgba_word    (rsp_rgba_word),
   .rsp_image_crc    (rsp_image_crc),
   .rsp_crc_final    (rsp_crc_final)
);
